@@ rtl/core/lcd_mode_timing_sequencer_macros.svh @@
// Assertion macros shared by the LCD timing sequencer RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef LCD_MODE_TIMING_SEQUENCER_MACROS_SVH
`define LCD_MODE_TIMING_SEQUENCER_MACROS_SVH

// Check a property on every rising clock edge outside of reset
`define LCDMTS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included
`define LCDMTS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/lcdmts_pkg.sv @@
// Types and constants of the LCD mode and scanline timing sequencer.
// No dependencies; used by the interfaces, the step logic and the top level.
package lcdmts_pkg;

  // default frame geometry
  localparam int unsigned VisibleLinesDef = 144;
  localparam int unsigned TotalLinesDef   = 154;

  // field widths
  localparam int unsigned DotsW  = 8;
  localparam int unsigned LineW  = 8;
  localparam int unsigned CountW = 16;
  localparam int unsigned ModeW  = 2;

  // register port
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // dot budget of each mode
  localparam logic [CountW-1:0] DotsScan   = 16'd80;
  localparam logic [CountW-1:0] DotsXfer   = 16'd172;
  localparam logic [CountW-1:0] DotsHblank = 16'd204;
  localparam logic [CountW-1:0] DotsLine   = 16'd456;

  typedef enum logic [ModeW-1:0] {
    ModeHblank = 2'd0,
    ModeVblank = 2'd1,
    ModeScan   = 2'd2,
    ModeXfer   = 2'd3
  } lcdmts_mode_e;

  typedef enum logic [2:0] {
    RegDisplayEn   = 3'd0,
    RegHblankIrqEn = 3'd1,
    RegVblankIrqEn = 3'd2,
    RegScanIrqEn   = 3'd3,
    RegCmpIrqEn    = 3'd4,
    RegLineCmp     = 3'd5
  } lcdmts_reg_e;

  typedef struct packed {
    logic             display_en;
    logic             hblank_irq_en;
    logic             vblank_irq_en;
    logic             scan_irq_en;
    logic             cmp_irq_en;
    logic [LineW-1:0] line_cmp;
  } lcdmts_cfg_t;

  typedef struct packed {
    lcdmts_mode_e      mode;
    logic [LineW-1:0]  line;
    logic [CountW-1:0] dots;
    logic              coin;
  } lcdmts_state_t;

  typedef struct packed {
    logic [LineW-1:0] line_number;
    logic [ModeW-1:0] lcd_mode;
    logic             coincidence;
    logic             status_irq;
    logic             vblank_irq;
    logic             frame_done;
    logic             line_done;
  } lcdmts_res_t;

endpackage

@@ rtl/core/lcdmts_chan_if.sv @@
// Valid/ready channels of the LCD timing sequencer: tick input and result output.
// Depends on lcdmts_pkg for field widths.
interface lcdmts_in_if import lcdmts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DotsW-1:0] elapsed_dots;

  modport source (output valid, output elapsed_dots, input ready);
  modport sink   (input valid, input elapsed_dots, output ready);
endinterface

interface lcdmts_out_if import lcdmts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LineW-1:0] line_number;
  logic [ModeW-1:0] lcd_mode;
  logic             coincidence;
  logic             status_irq;
  logic             vblank_irq;
  logic             frame_done;
  logic             line_done;

  modport source (
    output valid, output line_number, output lcd_mode, output coincidence,
    output status_irq, output vblank_irq, output frame_done, output line_done,
    input ready
  );
  modport sink (
    input valid, input line_number, input lcd_mode, input coincidence,
    input status_irq, input vblank_irq, input frame_done, input line_done,
    output ready
  );
endinterface

@@ rtl/core/lcd_mode_timing_sequencer.sv @@
// Top level of the LCD mode and scanline timing sequencer.
// Depends on lcdmts_pkg, lcdmts_chan_if, lcdmts_step and the assertion macros.
//
//   Channel   Direction  Payload                                     Handshake
//   tick_i    in         elapsed_dots                                valid/ready
//   result_o  out        line_number, lcd_mode, coincidence, irqs    valid/ready
//   apb       in/out     display/irq enables, line_compare           psel/penable
//
// One tick is taken every cycle while result_o does not stall; its result passes through the
// input register, then the result register, with the next-state logic in between.
// The timing state is updated only when a tick moves into the result register.
// Reset (rst_ni low) puts the mode to object scan, line and dot count to zero.
// While result_o stalls, the result register holds and one more tick is buffered.
`include "lcd_mode_timing_sequencer_macros.svh"

module lcd_mode_timing_sequencer import lcdmts_pkg::*; #(
  parameter int unsigned VISIBLE_LINES = VisibleLinesDef,
  parameter int unsigned TOTAL_LINES   = TotalLinesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  lcdmts_in_if.sink        tick_i,
  lcdmts_out_if.source     result_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  localparam logic [LineW-1:0] MaxLine = (VISIBLE_LINES > TOTAL_LINES - 1) ?
                                         LineW'(VISIBLE_LINES) : LineW'(TOTAL_LINES - 1);

  lcdmts_cfg_t      cfg_q;
  lcdmts_state_t    state_q;
  lcdmts_state_t    state_d;
  lcdmts_res_t      res_d;
  lcdmts_res_t      out_q;
  logic             in_vld_q;
  logic [DotsW-1:0] in_dots_q;
  logic             out_vld_q;
  logic             advance;
  logic             cfg_wr;
  lcdmts_reg_e      reg_sel;

  // register port: always ready, written on the access cycle
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = lcdmts_reg_e'(paddr[AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        RegDisplayEn:   cfg_q.display_en    <= pwdata[0];
        RegHblankIrqEn: cfg_q.hblank_irq_en <= pwdata[0];
        RegVblankIrqEn: cfg_q.vblank_irq_en <= pwdata[0];
        RegScanIrqEn:   cfg_q.scan_irq_en   <= pwdata[0];
        RegCmpIrqEn:    cfg_q.cmp_irq_en    <= pwdata[0];
        RegLineCmp:     cfg_q.line_cmp      <= pwdata[LineW-1:0];
        default:        cfg_q               <= cfg_q;
      endcase
    end
  end

  // read back the selected register
  always_comb begin
    case (reg_sel)
      RegDisplayEn:   prdata = {{(DataW - 1){1'b0}}, cfg_q.display_en};
      RegHblankIrqEn: prdata = {{(DataW - 1){1'b0}}, cfg_q.hblank_irq_en};
      RegVblankIrqEn: prdata = {{(DataW - 1){1'b0}}, cfg_q.vblank_irq_en};
      RegScanIrqEn:   prdata = {{(DataW - 1){1'b0}}, cfg_q.scan_irq_en};
      RegCmpIrqEn:    prdata = {{(DataW - 1){1'b0}}, cfg_q.cmp_irq_en};
      RegLineCmp:     prdata = {{(DataW - LineW){1'b0}}, cfg_q.line_cmp};
      default:        prdata = '0;
    endcase
  end

  // move a tick forward whenever the result register is free or drains
  assign advance      = !out_vld_q || result_o.ready;
  assign tick_i.ready = !in_vld_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (tick_i.ready) begin
      in_vld_q <= tick_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_i.valid && tick_i.ready) begin
      in_dots_q <= tick_i.elapsed_dots;
    end
  end

  lcdmts_step #(
    .VISIBLE_LINES(VISIBLE_LINES),
    .TOTAL_LINES  (TOTAL_LINES)
  ) u_step (
    .cfg_i  (cfg_q),
    .state_i(state_q),
    .dots_i (in_dots_q),
    .state_o(state_d),
    .res_o  (res_d)
  );

  // timing state: commit when the tick transfers into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode <= ModeScan;
      state_q.line <= '0;
      state_q.dots <= '0;
      state_q.coin <= 1'b0;
      out_vld_q    <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
      if (in_vld_q) begin
        state_q <= state_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (advance && in_vld_q) begin
      out_q <= res_d;
    end
  end

  assign result_o.valid       = out_vld_q;
  assign result_o.line_number = out_q.line_number;
  assign result_o.lcd_mode    = out_q.lcd_mode;
  assign result_o.coincidence = out_q.coincidence;
  assign result_o.status_irq  = out_q.status_irq;
  assign result_o.vblank_irq  = out_q.vblank_irq;
  assign result_o.frame_done  = out_q.frame_done;
  assign result_o.line_done   = out_q.line_done;

  // a stalled result freezes the timing state
  `LCDMTS_ASSERT(a_stall_holds_state, clk_i, rst_ni, (out_vld_q && !result_o.ready) |=> $stable(state_q), "timing state moved while result stalled")

  // a tick with the display off parks the timing at line zero in hblank
  `LCDMTS_ASSERT(a_disable_parks, clk_i, rst_ni, (advance && in_vld_q && !cfg_q.display_en) |=> (state_q.line == '0 && state_q.mode == ModeHblank && state_q.dots == '0), "display off did not park timing")

  // the line counter stays inside the frame
  `LCDMTS_ASSERT(a_line_bound, clk_i, rst_ni, state_q.line <= MaxLine, "line counter left the frame")

  // a finished frame is reported together with the vblank entry
  `LCDMTS_ASSERT(a_frame_in_vblank, clk_i, rst_ni, (advance && in_vld_q && res_d.frame_done) |=> (out_q.vblank_irq && state_q.mode == ModeVblank && state_q.line == LineW'(VISIBLE_LINES)), "frame done outside vblank entry")

endmodule

@@ rtl/core/lcdmts_step.sv @@
// Next-state and result logic for one tick of the LCD timing sequencer.
// Depends on lcdmts_pkg; instantiated by lcd_mode_timing_sequencer.
module lcdmts_step import lcdmts_pkg::*; #(
  parameter int unsigned VISIBLE_LINES = VisibleLinesDef,
  parameter int unsigned TOTAL_LINES   = TotalLinesDef
) (
  input  lcdmts_cfg_t      cfg_i,
  input  lcdmts_state_t    state_i,
  input  logic [DotsW-1:0] dots_i,
  output lcdmts_state_t    state_o,
  output lcdmts_res_t      res_o
);

  localparam logic [LineW-1:0] VisLine = LineW'(VISIBLE_LINES);
  localparam logic [LineW-1:0] TotLine = LineW'(TOTAL_LINES);

  logic [CountW:0]   dot_sum;
  logic [CountW-1:0] dot_sat;
  logic [LineW-1:0]  line_inc;
  logic              cmp_hit;
  logic              stat_irq;
  logic              vb_irq;
  logic              frame;
  logic              line_end;

  // saturate the dot counter, prepare the next line and its compare
  assign dot_sum  = {1'b0, state_i.dots} + {{(CountW + 1 - DotsW){1'b0}}, dots_i};
  assign dot_sat  = dot_sum[CountW] ? {CountW{1'b1}} : dot_sum[CountW-1:0];
  assign line_inc = state_i.line + LineW'(1);
  assign cmp_hit  = (line_inc == cfg_i.line_cmp);

  // advance at most one mode per tick
  always_comb begin
    state_o  = state_i;
    stat_irq = 1'b0;
    vb_irq   = 1'b0;
    frame    = 1'b0;
    line_end = 1'b0;
    if (!cfg_i.display_en) begin
      state_o.dots = '0;
      state_o.line = '0;
      state_o.mode = ModeHblank;
    end else begin
      state_o.dots = dot_sat;
      case (state_i.mode)
        ModeHblank: begin
          if (dot_sat >= DotsHblank) begin
            state_o.dots = dot_sat - DotsHblank;
            state_o.line = line_inc;
            state_o.coin = cmp_hit;
            stat_irq     = cmp_hit && cfg_i.cmp_irq_en;
            if (line_inc == VisLine) begin
              state_o.mode = ModeVblank;
              vb_irq       = 1'b1;
              frame        = 1'b1;
              stat_irq     = stat_irq || cfg_i.vblank_irq_en;
            end else begin
              state_o.mode = ModeScan;
              stat_irq     = stat_irq || cfg_i.scan_irq_en;
            end
          end
        end
        ModeVblank: begin
          if (dot_sat >= DotsLine) begin
            state_o.dots = dot_sat - DotsLine;
            state_o.line = line_inc;
            state_o.coin = cmp_hit;
            stat_irq     = cmp_hit && cfg_i.cmp_irq_en;
            // wrap to the top of the frame without a fresh compare
            if (line_inc >= TotLine) begin
              state_o.line = '0;
              state_o.mode = ModeScan;
              stat_irq     = stat_irq || cfg_i.scan_irq_en;
            end
          end
        end
        ModeScan: begin
          if (dot_sat >= DotsScan) begin
            state_o.dots = dot_sat - DotsScan;
            state_o.mode = ModeXfer;
          end
        end
        ModeXfer: begin
          if (dot_sat >= DotsXfer) begin
            state_o.dots = dot_sat - DotsXfer;
            state_o.mode = ModeHblank;
            line_end     = 1'b1;
            stat_irq     = cfg_i.hblank_irq_en;
          end
        end
        default: begin
          state_o.mode = state_i.mode;
        end
      endcase
    end
  end

  // pack the result of this tick
  assign res_o.line_number = state_o.line;
  assign res_o.lcd_mode    = state_o.mode;
  assign res_o.coincidence = state_o.coin;
  assign res_o.status_irq  = stat_irq;
  assign res_o.vblank_irq  = vb_irq;
  assign res_o.frame_done  = frame;
  assign res_o.line_done   = line_end;

endmodule
